>>> hdl/eatrm_pkg.sv
// Package for the Euler angle to rotation matrix block.
// Holds the CORDIC arctangent table, fixed-point constants and channel payload types.
package eatrm_pkg;
    localparam int ANGLE_BITS = 16;
    localparam int ENTRY_BITS = 16;
    localparam int FRAC = 30;
    localparam int IW = 34; // internal Q2.30 plus guard bits
    localparam logic signed [IW-1:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [IW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [IW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam int MAX_STAGES = 30;

    function automatic logic signed [IW-1:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0: v = 32'h3243F6A8;   1: v = 32'h1DAC6705;   2: v = 32'h0FADBAFC;
            3: v = 32'h07F56EA6;   4: v = 32'h03FEAB76;   5: v = 32'h01FFD55B;
            6: v = 32'h00FFFAAA;   7: v = 32'h007FFF55;   8: v = 32'h003FFFEA;
            9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF;  11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF;  14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF; 16: v = 32'h00003FFF;  17: v = 32'h00001FFF;
            18: v = 32'h00000FFF; 19: v = 32'h000007FF;  20: v = 32'h000003FF;
            21: v = 32'h000001FF; 22: v = 32'h000000FF;  23: v = 32'h0000007F;
            24: v = 32'h0000003F; 25: v = 32'h0000001F;  26: v = 32'h0000000F;
            27: v = 32'h00000008; 28: v = 32'h00000004;  29: v = 32'h00000002;
            default: v = 32'h0;
        endcase
        return $signed({2'b00, v});
    endfunction

    // Q2.30 product rounded back to Q2.30
    function automatic logic signed [IW-1:0] mulq(input logic signed [IW-1:0] a,
                                                  input logic signed [IW-1:0] b);
        logic signed [2*IW-1:0] p;
        p = a * b + (68'sd1 <<< (FRAC - 1));
        return p[FRAC+IW-1:FRAC];
    endfunction

    // input transaction: bank in the low bits
    typedef struct packed {
        logic [ANGLE_BITS-1:0] heading_angle;
        logic [ANGLE_BITS-1:0] attitude_angle;
        logic [ANGLE_BITS-1:0] bank_angle;
    } t_angles;

    // result transaction: r00 in the low bits
    typedef struct packed {
        logic [ENTRY_BITS-1:0] r22;
        logic [ENTRY_BITS-1:0] r21;
        logic [ENTRY_BITS-1:0] r20;
        logic [ENTRY_BITS-1:0] r12;
        logic [ENTRY_BITS-1:0] r11;
        logic [ENTRY_BITS-1:0] r10;
        logic [ENTRY_BITS-1:0] r02;
        logic [ENTRY_BITS-1:0] r01;
        logic [ENTRY_BITS-1:0] r00;
    } t_matrix;

    // per-angle data travelling down the cell chain
    typedef struct packed {
        logic signed [IW-1:0] x;
        logic signed [IW-1:0] y;
        logic signed [IW-1:0] z;
        logic                 neg;
    } t_rot;

    typedef struct packed {
        t_rot b;
        t_rot a;
        t_rot h;
    } t_cell_data;
endpackage

>>> hdl/eatrm_if.sv
// Valid/ready channel interface carrying a payload of type T.
// No dependencies.
interface eatrm_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

>>> hdl/eatrm_cell.sv
// One CORDIC micro-rotation cell applied to all three angles in parallel.
// Depends on eatrm_pkg.
module eatrm_cell #(
    parameter int STAGE = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  eatrm_pkg::t_cell_data i_data,
    output logic                  o_valid,
    output eatrm_pkg::t_cell_data o_data
);
    localparam logic signed [eatrm_pkg::IW-1:0] ATAN = eatrm_pkg::atan_q30(STAGE);

    function automatic eatrm_pkg::t_rot rot(input eatrm_pkg::t_rot r);
        eatrm_pkg::t_rot o;
        o = r;
        if (r.z >= 0) begin
            o.x = r.x - (r.y >>> STAGE);
            o.y = r.y + (r.x >>> STAGE);
            o.z = r.z - ATAN;
        end else begin
            o.x = r.x + (r.y >>> STAGE);
            o.y = r.y - (r.x >>> STAGE);
            o.z = r.z + ATAN;
        end
        return o;
    endfunction

    eatrm_pkg::t_cell_data r_data;
    logic                  r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data.b <= rot(i_data.b);
            r_data.a <= rot(i_data.a);
            r_data.h <= rot(i_data.h);
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

>>> hdl/euler_angles_to_rotation_matrix.sv
// Euler angles (bank x, attitude z, heading y, signed Q2.(ANGLE_BITS-3)) to the
// 3x3 rotation matrix (signed Q1.(ENTRY_BITS-2), saturated at +/-1). Fully
// pipelined: one transaction per cycle while the output is not stalled (one
// input stage, one cell per CORDIC stage, three product stages, one output
// register). A stall on the output freezes the whole pipeline.
module euler_angles_to_rotation_matrix #(
    parameter int CORDIC_STAGES = 14
) (
    input  logic i_clk,
    input  logic i_rst_n,
    eatrm_if.sink   s_in,
    eatrm_if.source m_out
);
    localparam int ANGLE_BITS = eatrm_pkg::ANGLE_BITS;
    localparam int ENTRY_BITS = eatrm_pkg::ENTRY_BITS;
    localparam int IW = eatrm_pkg::IW;
    localparam int SH = 33 - ANGLE_BITS;
    localparam longint BOUND = (longint'(eatrm_pkg::PI_Q30) + (longint'(1) << (SH - 1))) >>> SH;
    localparam int OSH = 32 - ENTRY_BITS;
    localparam longint ONE = longint'(1) << (ENTRY_BITS - 2);
    localparam int NST = CORDIC_STAGES;

    typedef logic signed [IW-1:0] t_q;

    logic en;
    logic r_pv [0:3];
    assign en = !r_pv[3] || m_out.ready;
    assign s_in.ready = en;

    // input stage: clamp, scale, quadrant reduce
    function automatic eatrm_pkg::t_rot prep(input logic [ANGLE_BITS-1:0] raw);
        eatrm_pkg::t_rot o;
        t_q v;
        v = t_q'($signed(raw));
        if (v > t_q'(BOUND)) v = t_q'(BOUND);
        if (v < -t_q'(BOUND)) v = -t_q'(BOUND);
        v = v <<< SH;
        o.neg = 1'b0;
        if (v > eatrm_pkg::HALF_PI_Q30) begin
            v = v - eatrm_pkg::PI_Q30; o.neg = 1'b1;
        end else if (v < -eatrm_pkg::HALF_PI_Q30) begin
            v = v + eatrm_pkg::PI_Q30; o.neg = 1'b1;
        end
        o.x = eatrm_pkg::GAIN_Q30;
        o.y = '0;
        o.z = v;
        return o;
    endfunction

    eatrm_pkg::t_cell_data chain_d [0:NST];
    logic                  chain_v [0:NST];
    eatrm_pkg::t_cell_data r_in;
    logic                  r_in_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (en) begin
            r_in_v <= s_in.valid;
        end
        if (en) begin
            r_in.b <= prep(s_in.data.bank_angle);
            r_in.a <= prep(s_in.data.attitude_angle);
            r_in.h <= prep(s_in.data.heading_angle);
        end
    end
    assign chain_d[0] = r_in;
    assign chain_v[0] = r_in_v;

    for (genvar g = 0; g < NST; g++) begin : g_cell
        eatrm_cell #(.STAGE(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
            .i_valid(chain_v[g]), .i_data(chain_d[g]),
            .o_valid(chain_v[g+1]), .o_data(chain_d[g+1])
        );
    end

    // sine/cosine with quadrant sign fix
    t_q sb, cb, sa, ca, sh, ch;
    always_comb begin
        sb = chain_d[NST].b.neg ? -chain_d[NST].b.y : chain_d[NST].b.y;
        cb = chain_d[NST].b.neg ? -chain_d[NST].b.x : chain_d[NST].b.x;
        sa = chain_d[NST].a.neg ? -chain_d[NST].a.y : chain_d[NST].a.y;
        ca = chain_d[NST].a.neg ? -chain_d[NST].a.x : chain_d[NST].a.x;
        sh = chain_d[NST].h.neg ? -chain_d[NST].h.y : chain_d[NST].h.y;
        ch = chain_d[NST].h.neg ? -chain_d[NST].h.x : chain_d[NST].h.x;
    end

    // product stage 1
    t_q r1_chsa, r1_shsa, r1_shsb, r1_chsb, r1_chca, r1_shca, r1_cacb, r1_casb;
    t_q r1_sa, r1_sb, r1_cb, r1_shcb, r1_chcb;
    // product stage 2
    t_q r2_chsacb, r2_chsasb, r2_shsacb, r2_shsasb;
    t_q r2_shsb, r2_shcb, r2_chsb, r2_chcb, r2_chca, r2_shca, r2_cacb, r2_casb, r2_sa;
    // sums
    t_q r3_m [0:8];
    logic [ENTRY_BITS-1:0] r_out [0:8];

    function automatic logic [ENTRY_BITS-1:0] entry(input t_q v);
        t_q r;
        if (OSH > 0) r = (v + (t_q'(1) <<< (OSH - 1))) >>> OSH;
        else r = v;
        if (r > t_q'(ONE)) r = t_q'(ONE);
        if (r < -t_q'(ONE)) r = -t_q'(ONE);
        return r[ENTRY_BITS-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv[0] <= 1'b0; r_pv[1] <= 1'b0; r_pv[2] <= 1'b0; r_pv[3] <= 1'b0;
        end else if (en) begin
            r_pv[0] <= chain_v[NST]; r_pv[1] <= r_pv[0];
            r_pv[2] <= r_pv[1];      r_pv[3] <= r_pv[2];
        end
        if (en) begin
            r1_chsa <= eatrm_pkg::mulq(ch, sa);
            r1_shsa <= eatrm_pkg::mulq(sh, sa);
            r1_shsb <= eatrm_pkg::mulq(sh, sb);
            r1_chsb <= eatrm_pkg::mulq(ch, sb);
            r1_chca <= eatrm_pkg::mulq(ch, ca);
            r1_shca <= eatrm_pkg::mulq(sh, ca);
            r1_cacb <= eatrm_pkg::mulq(ca, cb);
            r1_casb <= eatrm_pkg::mulq(ca, sb);
            r1_shcb <= eatrm_pkg::mulq(sh, cb);
            r1_chcb <= eatrm_pkg::mulq(ch, cb);
            r1_sa <= sa; r1_sb <= sb; r1_cb <= cb;

            r2_chsacb <= eatrm_pkg::mulq(r1_chsa, r1_cb);
            r2_chsasb <= eatrm_pkg::mulq(r1_chsa, r1_sb);
            r2_shsacb <= eatrm_pkg::mulq(r1_shsa, r1_cb);
            r2_shsasb <= eatrm_pkg::mulq(r1_shsa, r1_sb);
            r2_shsb <= r1_shsb; r2_shcb <= r1_shcb; r2_chsb <= r1_chsb;
            r2_chcb <= r1_chcb; r2_chca <= r1_chca; r2_shca <= r1_shca;
            r2_cacb <= r1_cacb; r2_casb <= r1_casb; r2_sa <= r1_sa;

            r3_m[0] <= r2_chca;
            r3_m[1] <= r2_shsb - r2_chsacb;
            r3_m[2] <= r2_chsasb + r2_shcb;
            r3_m[3] <= r2_sa;
            r3_m[4] <= r2_cacb;
            r3_m[5] <= -r2_casb;
            r3_m[6] <= -r2_shca;
            r3_m[7] <= r2_shsacb + r2_chsb;
            r3_m[8] <= r2_chcb - r2_shsasb;

            for (int k = 0; k < 9; k++) r_out[k] <= entry(r3_m[k]);
        end
    end

    assign m_out.valid = r_pv[3];
    assign m_out.data.r00 = r_out[0];
    assign m_out.data.r01 = r_out[1];
    assign m_out.data.r02 = r_out[2];
    assign m_out.data.r10 = r_out[3];
    assign m_out.data.r11 = r_out[4];
    assign m_out.data.r12 = r_out[5];
    assign m_out.data.r20 = r_out[6];
    assign m_out.data.r21 = r_out[7];
    assign m_out.data.r22 = r_out[8];
endmodule

>>> tb/sv/tb_euler_angles_to_rotation_matrix.sv
`timescale 1ns / 1ps
// Testbench for euler_angles_to_rotation_matrix: random and directed angle triples,
// predicted matrices checked in order. Depends on eatrm_pkg, eatrm_if and the block.
module tb_euler_angles_to_rotation_matrix;
    localparam int AW = eatrm_pkg::ANGLE_BITS;
    localparam int EW = eatrm_pkg::ENTRY_BITS;
    localparam int STAGES = 14;
    localparam int LATENCY = STAGES + 5;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic signed [AW-1:0] ANG_MAX = 16'sd25736;
    localparam logic signed [AW-1:0] ANG_HALF = 16'sd12868;
    localparam longint PI_Q30 = 64'sd3373259426;

    typedef logic [3*AW-1:0] t_angles;
    typedef logic [9*EW-1:0] t_matrix;

    // Q2.30 arithmetic in 64-bit words
    function automatic longint floor_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return floor_shr(a * b + (64'sd1 <<< 29), 30);
    endfunction

    function automatic longint widen_angle(input logic [AW-1:0] raw);
        longint v;
        v = longint'($signed(raw));
        if (v > 25736) v = 25736;
        if (v < -25736) v = -25736;
        return v * (64'sd1 <<< 17);
    endfunction

    function automatic void cordic_sincos(input longint ang, output longint s,
                                          output longint c);
        longint x, y, z, nx, step;
        bit flip;
        x = 652032874;
        y = 0;
        z = ang;
        flip = 0;
        if (z > 1686629713) begin
            z = z - PI_Q30;
            flip = 1;
        end else if (z < -1686629713) begin
            z = z + PI_Q30;
            flip = 1;
        end
        for (int i = 0; i < STAGES; i++) begin
            step = longint'(eatrm_pkg::atan_q30(i));
            if (z >= 0) begin
                nx = x - floor_shr(y, i);
                y = y + floor_shr(x, i);
                z = z - step;
            end else begin
                nx = x + floor_shr(y, i);
                y = y - floor_shr(x, i);
                z = z + step;
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic logic [EW-1:0] narrow_entry(input longint v);
        longint r;
        r = floor_shr(v + (64'sd1 <<< 15), 16);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[EW-1:0];
    endfunction

    function automatic t_matrix rotation_of(input t_angles ang);
        longint sb, cb, sa, ca, sh, ch;
        longint m[9];
        t_matrix res;
        cordic_sincos(widen_angle(ang[0*AW +: AW]), sb, cb);
        cordic_sincos(widen_angle(ang[1*AW +: AW]), sa, ca);
        cordic_sincos(widen_angle(ang[2*AW +: AW]), sh, ch);
        m[0] = qmul(ch, ca);
        m[1] = qmul(sh, sb) - qmul(qmul(ch, sa), cb);
        m[2] = qmul(qmul(ch, sa), sb) + qmul(sh, cb);
        m[3] = sa;
        m[4] = qmul(ca, cb);
        m[5] = -qmul(ca, sb);
        m[6] = -qmul(sh, ca);
        m[7] = qmul(qmul(sh, sa), cb) + qmul(ch, sb);
        m[8] = -qmul(qmul(sh, sa), sb) + qmul(ch, cb);
        for (int k = 0; k < 9; k++) res[k*EW +: EW] = narrow_entry(m[k]);
        return res;
    endfunction

    class matrix_scoreboard;
        t_matrix pending_q[$];
        int errors;

        function void note_angles(t_angles ang);
            pending_q.push_back(rotation_of(ang));
        endfunction

        function void check_matrix(t_matrix got);
            t_matrix want;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected matrix %h", $time, got);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            for (int k = 0; k < 9; k++) begin
                if (want[k*EW +: EW] !== got[k*EW +: EW]) begin
                    $display("%0t: entry %0d expected %0d actual %0d", $time, k,
                             $signed(want[k*EW +: EW]), $signed(got[k*EW +: EW]));
                    errors++;
                end
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    eatrm_if #(.T(eatrm_pkg::t_angles)) s_in ();
    eatrm_if #(.T(eatrm_pkg::t_matrix)) m_out ();
    matrix_scoreboard sb = new();
    int cycles = 0;
    bit no_idle = 0;
    bit stim_done = 0;

    euler_angles_to_rotation_matrix #(
        .CORDIC_STAGES(STAGES)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(s_in.sink), .m_out(m_out.source)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        s_in.valid = 0;
        s_in.data = '0;
        m_out.ready = 0;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 17);
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        if (i_rst_n && s_in.valid && s_in.ready) sb.note_angles(s_in.data);
        if (i_rst_n && m_out.valid && m_out.ready) sb.check_matrix(m_out.data);
    end

    // result side: hold ready low for a drawn gap before each transaction
    initial begin
        int w;
        @(posedge i_clk iff i_rst_n);
        forever begin
            w = draw_gap();
            if (w > 0) begin
                m_out.ready <= 0;
                repeat (w) @(posedge i_clk);
            end
            m_out.ready <= 1;
            @(posedge i_clk);
            while (!m_out.valid) @(posedge i_clk);
        end
    end

    task automatic send_angles(input logic [AW-1:0] b, input logic [AW-1:0] a,
                               input logic [AW-1:0] h);
        int w;
        w = draw_gap();
        if (w > 0) begin
            s_in.valid <= 0;
            repeat (w) @(posedge i_clk);
        end
        s_in.valid <= 1;
        s_in.data <= {h, a, b};
        @(posedge i_clk);
        while (!s_in.ready) @(posedge i_clk);
    endtask

    function automatic logic [AW-1:0] rand_angle();
        case ($urandom_range(0, 9))
            0: return AW'($urandom);
            1: return $urandom_range(0, 1) ? ANG_MAX : -ANG_MAX;
            2: return ANG_HALF + AW'($urandom_range(0, 4)) - 16'sd2;
            3: return -ANG_HALF + AW'($urandom_range(0, 4)) - 16'sd2;
            default: return AW'($urandom_range(0, 2 * 25736) - 25736);
        endcase
    endfunction

    initial begin
        logic [AW-1:0] dir[12];
        dir = '{16'sd0, ANG_MAX, -ANG_MAX, 16'sd32767, -16'sd32768, ANG_HALF,
                ANG_HALF + 16'sd1, -ANG_HALF, -ANG_HALF - 16'sd1, 16'sd1, -16'sd1,
                16'sd25737};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        for (int i = 0; i < 12; i++) send_angles(dir[i], dir[(i + 4) % 12], dir[(i + 8) % 12]);
        send_angles(dir[3], dir[3], dir[3]);
        send_angles(dir[4], dir[4], dir[4]);
        send_angles(dir[1], dir[5], dir[2]);
        // hold off until the pipeline has drained
        s_in.valid <= 0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        for (int n = 0; n < 550; n++) begin
            if (n % 60 == 0) no_idle = ($urandom_range(0, 2) == 0);
            send_angles(rand_angle(), rand_angle(), rand_angle());
        end
        s_in.valid <= 0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

>>> euler_angles_to_rotation_matrix.f
hdl/eatrm_pkg.sv
hdl/eatrm_if.sv
hdl/eatrm_cell.sv
hdl/euler_angles_to_rotation_matrix.sv
tb/sv/tb_euler_angles_to_rotation_matrix.sv
